FILE: hw/rtl/wena_pkg.sv
package wena_pkg;

  localparam int DATA_WIDTH = 32;
  localparam logic [31:0] FIELD_MASK = 32'((64'd1 << DATA_WIDTH) - 64'd1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  localparam int ROOT_W = 34;
  localparam int RAD_W  = 2 * ROOT_W;

  localparam logic REG_VALUE_ON = 1'b0;
  localparam logic REG_GRAD_ON  = 1'b1;

  typedef struct packed {
    logic [31:0] val_err;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
    logic [31:0] weight;
    logic        last;
    logic        value_on;
    logic        grad_on;
  } item_t;

  typedef struct packed {
    logic [63:0] value_l1;
    logic [31:0] value_l2;
    logic [31:0] value_peak;
    logic [63:0] grad_l1;
    logic [31:0] grad_l2;
    logic [31:0] grad_peak;
    logic        saturated;
  } result_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  // Sign-extend the low DATA_WIDTH bits to 33 bits.
  function automatic logic signed [32:0] sext33(input logic [31:0] x);
    logic [31:0] m;
    m = x & FIELD_MASK;
    if (x[DATA_WIDTH-1]) m = m | ~FIELD_MASK;
    return {m[31], m};
  endfunction

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    logic [32:0] n;
    d = sext33(a) - sext33(b);
    n = -d;
    return d[32] ? n[31:0] : d[31:0];
  endfunction

endpackage

FILE: hw/rtl/wena_sqrt.sv
module wena_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wena_pkg::RAD_W-1:0]    radicand,
  output wena_pkg::sqrt_rsp_t           rsp
);

  logic                          busy_r;
  logic                          done_r;
  logic [5:0]                    cnt_r;
  logic [wena_pkg::RAD_W-1:0]    rad_r;
  logic [wena_pkg::ROOT_W+2:0]   rem_r;
  logic [wena_pkg::ROOT_W-1:0]   root_r;

  logic [wena_pkg::ROOT_W+2:0]   rem_sh;
  logic [wena_pkg::ROOT_W+2:0]   trial;
  logic [wena_pkg::ROOT_W+2:0]   rem_nxt;
  logic [wena_pkg::ROOT_W-1:0]   root_nxt;

  // One result bit per cycle: bring down two radicand bits, try root*4+1.
  always_comb begin
    rem_sh = {rem_r[wena_pkg::ROOT_W:0], rad_r[wena_pkg::RAD_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_r[wena_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_r[wena_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(wena_pkg::ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[wena_pkg::RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

FILE: hw/rtl/wena_front.sv
module wena_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [31:0]         value_exact,
  input  logic [31:0]         value_approx,
  input  logic [31:0]         grad_exact_x,
  input  logic [31:0]         grad_exact_y,
  input  logic [31:0]         grad_exact_z,
  input  logic [31:0]         grad_approx_x,
  input  logic [31:0]         grad_approx_y,
  input  logic [31:0]         grad_approx_z,
  input  logic [31:0]         weight,
  input  logic                last_of_set,
  input  logic                value_on,
  input  logic                grad_on,
  output logic                q_valid,
  output wena_pkg::item_t     q_item,
  input  logic                q_pop
);

  wena_pkg::item_t               mem [wena_pkg::QDEPTH];
  wena_pkg::item_t               item_nxt;
  logic [wena_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [wena_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [wena_pkg::QPTR_W:0]     count_r;
  logic                          wr_en;

  // Classify: reduce each pair to its error magnitude, latch the enables.
  always_comb begin
    item_nxt.val_err  = wena_pkg::abs_diff(value_exact, value_approx);
    item_nxt.dx       = wena_pkg::abs_diff(grad_exact_x, grad_approx_x);
    item_nxt.dy       = wena_pkg::abs_diff(grad_exact_y, grad_approx_y);
    item_nxt.dz       = wena_pkg::abs_diff(grad_exact_z, grad_approx_z);
    item_nxt.weight   = weight & wena_pkg::FIELD_MASK;
    item_nxt.last     = last_of_set;
    item_nxt.value_on = value_on;
    item_nxt.grad_on  = grad_on;
  end

  assign full    = (count_r == (wena_pkg::QPTR_W + 1)'(wena_pkg::QDEPTH));
  assign wr_en   = push && !full;
  assign q_valid = (count_r != '0);
  assign q_item  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr_r] <= item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (wena_pkg::QPTR_W + 1)'(wr_en)
                         - (wena_pkg::QPTR_W + 1)'(q_pop);
    end
  end

endmodule

FILE: hw/rtl/wena_back.sv
module wena_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  wena_pkg::item_t     q_item,
  output logic                q_pop,
  input  logic                pop,
  output logic                out_valid,
  output wena_pkg::result_t   res
);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_CALC   = 11'b00000000010,
    ST_GROOT  = 11'b00000000100,
    ST_GMUL   = 11'b00000001000,
    ST_GL1    = 11'b00000010000,
    ST_ACC    = 11'b00000100000,
    ST_VSTART = 11'b00001000000,
    ST_VWAIT  = 11'b00010000000,
    ST_GSTART = 11'b00100000000,
    ST_GWAIT  = 11'b01000000000,
    ST_EMIT   = 11'b10000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [3:0]        step_r;
  wena_pkg::item_t   it_r;

  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod_r;
  logic [63:0]       aw_r;
  logic [63:0]       tlo_r;
  logic [95:0]       vsq_r;
  logic [65:0]       g2_r;
  logic [97:0]       gsq_r;
  logic [33:0]       gabs_r;
  logic [65:0]       gl1_r;
  logic [33:0]       g2hi_w;
  logic [33:0]       gabshi_w;

  logic [63:0]       vabs_sum_r, vsq_sum_r, gabs_sum_r, gsq_sum_r;
  logic [31:0]       vmax_r, gmax_r;
  logic              ovf_r;
  logic [31:0]       vl2_r;

  logic              out_valid_r;
  wena_pkg::result_t res_r;

  logic                           sq_start;
  logic [wena_pkg::RAD_W-1:0]     sq_rad;
  wena_pkg::sqrt_rsp_t            sq_rsp;

  logic [63:0] vsq_term, gl1_term, gsq_term;
  logic [31:0] gpk;
  logic [64:0] vabs_add, vsq_add, gabs_add, gsq_add;
  logic        ovf_v, ovf_g;

  wena_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .rsp      (sq_rsp)
  );

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  // Shared multiplier operands, one product per cycle.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_GMUL) begin
      mul_a = gabs_r[31:0];
      mul_b = it_r.weight;
    end else if (state_r == ST_CALC) begin
      unique case (step_r)
        4'd0: begin mul_a = it_r.val_err; mul_b = it_r.weight;      end
        4'd1: begin mul_a = it_r.val_err; mul_b = prod_r[31:0];     end
        4'd2: begin mul_a = it_r.val_err; mul_b = aw_r[63:32];      end
        4'd3: begin mul_a = it_r.dx;      mul_b = it_r.dx;          end
        4'd4: begin mul_a = it_r.dy;      mul_b = it_r.dy;          end
        4'd5: begin mul_a = it_r.dz;      mul_b = it_r.dz;          end
        4'd7: begin mul_a = g2_r[31:0];   mul_b = it_r.weight;      end
        4'd8: begin mul_a = g2_r[63:32];  mul_b = it_r.weight;      end
        default: begin mul_a = '0;        mul_b = '0;               end
      endcase
    end
  end

  always_comb begin
    sq_start = 1'b0;
    sq_rad   = '0;
    if (state_r == ST_CALC && step_r == 4'd7) begin
      sq_start = 1'b1;
      sq_rad   = {2'b00, g2_r};
    end else if (state_r == ST_VSTART) begin
      sq_start = 1'b1;
      sq_rad   = {4'b0000, vsq_sum_r};
    end else if (state_r == ST_GSTART) begin
      sq_start = 1'b1;
      sq_rad   = {4'b0000, gsq_sum_r};
    end
  end

  assign g2hi_w   = 34'(g2_r[65:64]) * 34'(it_r.weight);
  assign gabshi_w = 34'(gabs_r[33:32]) * 34'(it_r.weight);

  // Saturate the terms, then saturate the sums.
  always_comb begin
    vsq_term = (|vsq_r[95:80]) ? '1 : vsq_r[79:16];
    gl1_term = (|gl1_r[65:64]) ? '1 : gl1_r[63:0];
    gsq_term = (|gsq_r[97:80]) ? '1 : gsq_r[79:16];
    gpk      = (|gabs_r[33:32]) ? '1 : gabs_r[31:0];
    vabs_add = {1'b0, vabs_sum_r} + {1'b0, aw_r};
    vsq_add  = {1'b0, vsq_sum_r}  + {1'b0, vsq_term};
    gabs_add = {1'b0, gabs_sum_r} + {1'b0, gl1_term};
    gsq_add  = {1'b0, gsq_sum_r}  + {1'b0, gsq_term};
    ovf_v    = (|vsq_r[95:80]) || vabs_add[64] || vsq_add[64];
    ovf_g    = (|gl1_r[65:64]) || (|gsq_r[97:80]) || (|gabs_r[33:32])
               || gabs_add[64] || gsq_add[64];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (q_valid) state_nxt = ST_CALC;
      ST_CALC:   if (step_r == 4'd9) state_nxt = ST_GROOT;
      ST_GROOT:  if (sq_rsp.done) state_nxt = ST_GMUL;
      ST_GMUL:   state_nxt = ST_GL1;
      ST_GL1:    state_nxt = ST_ACC;
      ST_ACC:    state_nxt = it_r.last ? ST_VSTART : ST_IDLE;
      ST_VSTART: state_nxt = ST_VWAIT;
      ST_VWAIT:  if (sq_rsp.done) state_nxt = ST_GSTART;
      ST_GSTART: state_nxt = ST_GWAIT;
      ST_GWAIT:  if (sq_rsp.done) state_nxt = ST_EMIT;
      ST_EMIT:   if (!out_valid_r) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      vabs_sum_r  <= '0;
      vsq_sum_r   <= '0;
      gabs_sum_r  <= '0;
      gsq_sum_r   <= '0;
      vmax_r      <= '0;
      gmax_r      <= '0;
      ovf_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) step_r <= '0;
      else if (state_r == ST_CALC) step_r <= step_r + 4'd1;

      if (pop && out_valid_r) out_valid_r <= 1'b0;

      if (state_r == ST_ACC) begin
        if (it_r.value_on) begin
          vabs_sum_r <= vabs_add[64] ? '1 : vabs_add[63:0];
          vsq_sum_r  <= vsq_add[64]  ? '1 : vsq_add[63:0];
          if (it_r.val_err > vmax_r) vmax_r <= it_r.val_err;
        end
        if (it_r.grad_on) begin
          gabs_sum_r <= gabs_add[64] ? '1 : gabs_add[63:0];
          gsq_sum_r  <= gsq_add[64]  ? '1 : gsq_add[63:0];
          if (gpk > gmax_r) gmax_r <= gpk;
        end
        if ((it_r.value_on && ovf_v) || (it_r.grad_on && ovf_g)) ovf_r <= 1'b1;
      end

      // Hand the set to the output slot, then clear for the next set.
      if (state_r == ST_EMIT && !out_valid_r) begin
        out_valid_r <= 1'b1;
        vabs_sum_r  <= '0;
        vsq_sum_r   <= '0;
        gabs_sum_r  <= '0;
        gsq_sum_r   <= '0;
        vmax_r      <= '0;
        gmax_r      <= '0;
        ovf_r       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (q_pop) it_r <= q_item;
    if (state_r == ST_CALC) begin
      unique case (step_r)
        4'd1: aw_r  <= prod_r;
        4'd2: tlo_r <= prod_r;
        4'd3: vsq_r <= {prod_r, 32'd0} + {32'd0, tlo_r};
        4'd4: g2_r  <= {2'b00, prod_r};
        4'd5: g2_r  <= g2_r + {2'b00, prod_r};
        4'd6: g2_r  <= g2_r + {2'b00, prod_r};
        4'd8: tlo_r <= prod_r;
        4'd9: gsq_r <= {2'b00, prod_r, 32'd0} + {34'd0, tlo_r} + {g2hi_w, 64'd0};
        default: ;
      endcase
    end
    if (state_r == ST_GROOT && sq_rsp.done) gabs_r <= sq_rsp.root;
    if (state_r == ST_GL1) gl1_r <= {2'b00, prod_r} + {gabshi_w, 32'd0};
    if (state_r == ST_VWAIT && sq_rsp.done) vl2_r <= sq_rsp.root[31:0];
    if (state_r == ST_EMIT && !out_valid_r) begin
      res_r.value_l1   <= vabs_sum_r;
      res_r.value_l2   <= vl2_r;
      res_r.value_peak <= vmax_r;
      res_r.grad_l1    <= gabs_sum_r;
      res_r.grad_l2    <= sq_rsp.root[31:0];
      res_r.grad_peak  <= gmax_r;
      res_r.saturated  <= ovf_r;
    end
  end

endmodule

FILE: hw/rtl/weighted_error_norm_accumulator.sv
// Per item the back end takes the item, runs 10 multiply steps, waits on the
// 34-step bit-serial magnitude root, then finishes and adds in GMUL, GL1, ACC.
// A set-closing item then runs the two L2 roots, value first, before its result
// goes to the output slot once that is free; the back end takes no new item
// until it is through with the last, and a two-entry queue decouples input.
// Reset (synchronous, rst_n low): sums, peaks, flag, queue and output slot clear; enables set.
module weighted_error_norm_accumulator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_value_exact,
  input  logic [31:0] in_value_approx,
  input  logic [31:0] in_grad_exact_x,
  input  logic [31:0] in_grad_exact_y,
  input  logic [31:0] in_grad_exact_z,
  input  logic [31:0] in_grad_approx_x,
  input  logic [31:0] in_grad_approx_y,
  input  logic [31:0] in_grad_approx_z,
  input  logic [31:0] in_weight,
  input  logic        in_last_of_set,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_value_l1,
  output logic [31:0] out_value_l2,
  output logic [31:0] out_value_peak,
  output logic [63:0] out_grad_l1,
  output logic [31:0] out_grad_l2,
  output logic [31:0] out_grad_peak,
  output logic        out_saturated,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata
);

  logic              value_on_r;
  logic              grad_on_r;
  logic              q_valid;
  logic              q_pop;
  wena_pkg::item_t   q_item;
  logic              out_valid;
  wena_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_on_r <= 1'b1;
      grad_on_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wena_pkg::REG_VALUE_ON: value_on_r <= cfg_wdata;
        wena_pkg::REG_GRAD_ON:  grad_on_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  wena_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .value_exact   (in_value_exact),
    .value_approx  (in_value_approx),
    .grad_exact_x  (in_grad_exact_x),
    .grad_exact_y  (in_grad_exact_y),
    .grad_exact_z  (in_grad_exact_z),
    .grad_approx_x (in_grad_approx_x),
    .grad_approx_y (in_grad_approx_y),
    .grad_approx_z (in_grad_approx_z),
    .weight        (in_weight),
    .last_of_set   (in_last_of_set),
    .value_on      (value_on_r),
    .grad_on       (grad_on_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  wena_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .res       (res)
  );

  assign empty          = !out_valid;
  assign out_value_l1   = res.value_l1;
  assign out_value_l2   = res.value_l2;
  assign out_value_peak = res.value_peak;
  assign out_grad_l1    = res.grad_l1;
  assign out_grad_l2    = res.grad_l2;
  assign out_grad_peak  = res.grad_peak;
  assign out_saturated  = res.saturated;

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back end took an item from an empty queue");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (empty && !full && !q_valid))
    else $error("queues not cleared after reset");

  a_one_take: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop)
    else $error("back end took two items in a row");

endmodule
